// File: design/lps_pkg.sv
// lps_pkg: shared types and constants for the line point stepper
// no dependencies; compile first

package lps_pkg;

  // width of every coordinate and color field on the channels
  localparam int FIELD_BITS = 16;

  // item command codes
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // per-axis step, two's complement
  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b11
  } dir_t;

endpackage

// File: design/lps_in_if.sv
// lps_in_if: command channel into the line point stepper
// depends on lps_pkg

interface lps_in_if;
  import lps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [FIELD_BITS-1:0] start_x;
  logic [FIELD_BITS-1:0] start_y;
  logic [FIELD_BITS-1:0] end_x;
  logic [FIELD_BITS-1:0] end_y;

  modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: design/lps_out_if.sv
// lps_out_if: point channel out of the line point stepper
// depends on lps_pkg

interface lps_out_if;
  import lps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] point_x;
  logic [FIELD_BITS-1:0] point_y;
  logic [FIELD_BITS-1:0] color;
  logic                  last;

  modport source (output valid, point_x, point_y, color, last, input ready);
  modport sink   (input valid, point_x, point_y, color, last, output ready);
endinterface

// File: design/lps_axis_setup.sv
// lps_axis_setup: absolute delta and step direction for one axis
// depends on lps_pkg

module lps_axis_setup #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0] from_c,
  input  logic [COORD_BITS-1:0] to_c,
  output logic [COORD_BITS-1:0] mag,
  output lps_pkg::dir_t         dir
);
  import lps_pkg::*;

  always_comb begin
    if (to_c > from_c) begin
      mag = to_c - from_c;
      dir = DIR_UP;
    end else if (to_c < from_c) begin
      mag = from_c - to_c;
      dir = DIR_DOWN;
    end else begin
      mag = '0;
      dir = DIR_NONE;
    end
  end
endmodule

// File: design/lps_axis_step.sv
// lps_axis_step: error update and coordinate move for one axis
// depends on lps_pkg

module lps_axis_step #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0] cur,
  input  logic [COORD_BITS+1:0] err,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [COORD_BITS-1:0] major,
  input  lps_pkg::dir_t         dir,
  output logic [COORD_BITS-1:0] cur_next,
  output logic [COORD_BITS+1:0] err_next
);
  import lps_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 2;

  logic [ERR_BITS-1:0] sum;
  logic [ERR_BITS-1:0] major_ext;

  assign sum       = err + ERR_BITS'(mag);
  assign major_ext = ERR_BITS'(major);

  always_comb begin
    err_next = sum;
    cur_next = cur;
    if (sum > major_ext) begin
      err_next = sum - major_ext;
      case (dir)
        DIR_UP:   cur_next = cur + COORD_BITS'(1);
        DIR_DOWN: cur_next = cur - COORD_BITS'(1);
        default:  cur_next = cur;
      endcase
    end
  end
endmodule

// File: design/line_point_stepper.sv
// line_point_stepper: line rasterizer, one point per step item taken on an active line
// an item is registered in the input stage on accept; a step item's point moves on
//   into the output register once free; the stepper loop is one add/compare per axis
// throughput: one item per cycle while the point sink does not stall the output
// reset: synchronous active-high rst clears all control and line state; pen_color is 0
// depends on lps_pkg, lps_in_if, lps_out_if, lps_axis_setup, lps_axis_step

module line_point_stepper #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lps_pkg::FIELD_BITS-1:0]  cfg_wdata,
  lps_in_if.sink                          items,
  lps_out_if.source                       points
);
  import lps_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 2;
  localparam int CNT_BITS = COORD_BITS + 1;

  // pen color register, read when each point is produced
  logic [FIELD_BITS-1:0] pen_color;

  // input register stage
  logic                  s1_valid;
  cmd_t                  s1_cmd;
  logic [COORD_BITS-1:0] s1_sx, s1_sy, s1_ex, s1_ey;

  // line state
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic [COORD_BITS-1:0] abs_dx, abs_dy;
  dir_t                  dir_x, dir_y;
  logic [COORD_BITS-1:0] major_len;
  logic [ERR_BITS-1:0]   err_x, err_y;
  logic [CNT_BITS-1:0]   points_left;
  logic                  active;

  // output register
  logic                  out_valid;
  logic [FIELD_BITS-1:0] out_x, out_y, out_color;
  logic                  out_last;

  // handshake: the input stage moves on whenever the output register is free
  logic out_free, s1_go, in_take;

  assign out_free    = !out_valid || points.ready;
  assign s1_go       = s1_valid && out_free;
  assign items.ready = !s1_valid || out_free;
  assign in_take     = items.valid && items.ready;

  // load-time setup from the registered endpoints
  logic [COORD_BITS-1:0] set_dx, set_dy, set_major;
  dir_t                  set_dir_x, set_dir_y;

  lps_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup_x (
    .from_c (s1_sx),
    .to_c   (s1_ex),
    .mag    (set_dx),
    .dir    (set_dir_x)
  );

  lps_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup_y (
    .from_c (s1_sy),
    .to_c   (s1_ey),
    .mag    (set_dy),
    .dir    (set_dir_y)
  );

  assign set_major = (set_dx > set_dy) ? set_dx : set_dy;

  // per-point error update and move
  logic [COORD_BITS-1:0] step_x, step_y;
  logic [ERR_BITS-1:0]   step_err_x, step_err_y;

  lps_axis_step #(.COORD_BITS(COORD_BITS)) u_step_x (
    .cur      (cur_x),
    .err      (err_x),
    .mag      (abs_dx),
    .major    (major_len),
    .dir      (dir_x),
    .cur_next (step_x),
    .err_next (step_err_x)
  );

  lps_axis_step #(.COORD_BITS(COORD_BITS)) u_step_y (
    .cur      (cur_y),
    .err      (err_y),
    .mag      (abs_dy),
    .major    (major_len),
    .dir      (dir_y),
    .cur_next (step_y),
    .err_next (step_err_y)
  );

  logic is_load, is_point, final_point;

  assign is_load     = s1_go && (s1_cmd == CMD_LOAD);
  assign is_point    = s1_go && (s1_cmd == CMD_STEP) && active;
  assign final_point = (points_left == CNT_BITS'(1));

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_color <= '0;
    end else if (cfg_we) begin
      pen_color <= cfg_wdata;
    end
  end

  // input stage: valid bit plus payload, endpoint bits above COORD_BITS dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd <= cmd_t'(items.command);
      s1_sx  <= items.start_x[COORD_BITS-1:0];
      s1_sy  <= items.start_y[COORD_BITS-1:0];
      s1_ex  <= items.end_x[COORD_BITS-1:0];
      s1_ey  <= items.end_y[COORD_BITS-1:0];
    end
  end

  // line state: a load restarts the line, a step advances it while active
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      dir_x       <= DIR_NONE;
      dir_y       <= DIR_NONE;
      major_len   <= '0;
      err_x       <= '0;
      err_y       <= '0;
      points_left <= '0;
      active      <= 1'b0;
    end else if (is_load) begin
      cur_x       <= s1_sx;
      cur_y       <= s1_sy;
      abs_dx      <= set_dx;
      abs_dy      <= set_dy;
      dir_x       <= set_dir_x;
      dir_y       <= set_dir_y;
      major_len   <= set_major;
      err_x       <= '0;
      err_y       <= '0;
      // major_len + 2 points, first one repeated
      points_left <= CNT_BITS'(set_major) + CNT_BITS'(2);
      active      <= 1'b1;
    end else if (is_point) begin
      cur_x       <= step_x;
      cur_y       <= step_y;
      err_x       <= step_err_x;
      err_y       <= step_err_y;
      points_left <= points_left - CNT_BITS'(1);
      // the flagged point ends the line, also for the longest one
      if (final_point) begin
        active <= 1'b0;
      end
    end
  end

  // output register: refilled whenever the input stage moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= is_point;
    end
  end

  always_ff @(posedge clk) begin
    if (is_point) begin
      out_x     <= FIELD_BITS'(cur_x);
      out_y     <= FIELD_BITS'(cur_y);
      out_color <= pen_color;
      out_last  <= final_point;
    end
  end

  assign points.valid   = out_valid;
  assign points.point_x = out_x;
  assign points.point_y = out_y;
  assign points.color   = out_color;
  assign points.last    = out_last;
endmodule

// File: tb/sv/lps_trace_pkg.sv
`timescale 1ns / 1ps
// lps_trace_pkg: point tracer and scoreboard for the line point stepper bench
// depends on lps_pkg

package lps_trace_pkg;
  import lps_pkg::*;

  typedef struct packed {
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] color;
    logic                  last;
  } point_t;

  class point_board;
    point_t                pending_points[$];
    logic [FIELD_BITS-1:0] pen;
    logic [FIELD_BITS-1:0] cur_x, cur_y;
    logic [FIELD_BITS-1:0] dx_abs, dy_abs;
    logic [FIELD_BITS-1:0] major;
    dir_t                  dir_x, dir_y;
    logic [17:0]           err_x, err_y;
    logic [16:0]           left;
    bit                    active;
    int                    errors;
    int                    checked;
    int                    lines;

    function new();
      pen     = '0;
      cur_x   = '0;
      cur_y   = '0;
      dx_abs  = '0;
      dy_abs  = '0;
      major   = '0;
      dir_x   = DIR_NONE;
      dir_y   = DIR_NONE;
      err_x   = '0;
      err_y   = '0;
      left    = '0;
      active  = 0;
      errors  = 0;
      checked = 0;
      lines   = 0;
    endfunction

    function void set_color(logic [FIELD_BITS-1:0] v);
      pen = v;
    endfunction

    function void setup_axis(input logic [FIELD_BITS-1:0] from, input logic [FIELD_BITS-1:0] to,
                             output logic [FIELD_BITS-1:0] mag, output dir_t dir);
      if (to > from) begin
        mag = to - from;
        dir = DIR_UP;
      end else if (to < from) begin
        mag = from - to;
        dir = DIR_DOWN;
      end else begin
        mag = '0;
        dir = DIR_NONE;
      end
    endfunction

    function logic [FIELD_BITS-1:0] nudge(logic [FIELD_BITS-1:0] c, dir_t d);
      case (d)
        DIR_UP:   return c + 1'b1;
        DIR_DOWN: return c - 1'b1;
        default:  return c;
      endcase
    endfunction

    // advance the tracer by one accepted item; returns 0 for an ignored step
    function bit note_item(cmd_t cmd, logic [FIELD_BITS-1:0] sx, logic [FIELD_BITS-1:0] sy,
                           logic [FIELD_BITS-1:0] ex, logic [FIELD_BITS-1:0] ey);
      point_t p;
      if (cmd == CMD_LOAD) begin
        setup_axis(sx, ex, dx_abs, dir_x);
        setup_axis(sy, ey, dy_abs, dir_y);
        major  = (dx_abs > dy_abs) ? dx_abs : dy_abs;
        cur_x  = sx;
        cur_y  = sy;
        err_x  = '0;
        err_y  = '0;
        left   = {1'b0, major} + 17'd2;
        active = 1;
        lines++;
        return 1;
      end
      if (!active) return 0;
      p.x     = cur_x;
      p.y     = cur_y;
      p.color = pen;
      p.last  = (left == 17'd1);
      pending_points.push_back(p);
      err_x = err_x + {2'b00, dx_abs};
      err_y = err_y + {2'b00, dy_abs};
      if (err_x > {2'b00, major}) begin
        err_x = err_x - {2'b00, major};
        cur_x = nudge(cur_x, dir_x);
      end
      if (err_y > {2'b00, major}) begin
        err_y = err_y - {2'b00, major};
        cur_y = nudge(cur_y, dir_y);
      end
      left = left - 1'b1;
      if (left == 0) active = 0;
      return 1;
    endfunction

    function void check_point(logic [FIELD_BITS-1:0] x, logic [FIELD_BITS-1:0] y,
                              logic [FIELD_BITS-1:0] color, logic last);
      point_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t unexpected point x %h y %h color %h last %b", $time, x, y, color, last);
        return;
      end
      want = pending_points.pop_front();
      checked++;
      if (x !== want.x) begin
        errors++;
        $display("%0t point_x expected %h got %h", $time, want.x, x);
      end
      if (y !== want.y) begin
        errors++;
        $display("%0t point_y expected %h got %h", $time, want.y, y);
      end
      if (color !== want.color) begin
        errors++;
        $display("%0t color expected %h got %h", $time, want.color, color);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t last expected %b got %b", $time, want.last, last);
      end
    endfunction
  endclass

endpackage

// File: tb/sv/line_point_stepper_tb.sv
`timescale 1ns / 1ps
// line_point_stepper_tb: drives load and step items with random gaps and stalls,
// traces every line in a scoreboard and checks each point field by field
// depends on lps_pkg, lps_in_if, lps_out_if, lps_trace_pkg, line_point_stepper

module line_point_stepper_tb;
  import lps_pkg::*;
  import lps_trace_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [FIELD_BITS-1:0] cfg_wdata;

  lps_in_if  items_bus ();
  lps_out_if points_bus ();

  line_point_stepper dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .items     (items_bus),
    .points    (points_bus)
  );

  point_board board;
  bit         calm;          // when set, neither side starts a new idle gap
  int         cycles;
  int         color_writes;
  int         sent;          // items that did something (ignored steps excluded)

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length for either side: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // point sink: check on handshake, then decide ready for the next edge
  initial begin
    int stall_left;
    stall_left = 0;
    points_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && points_bus.valid && points_bus.ready)
        board.check_point(points_bus.point_x, points_bus.point_y, points_bus.color,
                          points_bus.last);
      if (stall_left > 0) begin
        points_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        points_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // one item: optional gap with valid low, then hold until ready
  task automatic send(cmd_t cmd, logic [FIELD_BITS-1:0] sx, logic [FIELD_BITS-1:0] sy,
                      logic [FIELD_BITS-1:0] ex, logic [FIELD_BITS-1:0] ey);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      items_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_bus.valid   <= 1'b1;
    items_bus.command <= cmd;
    items_bus.start_x <= sx;
    items_bus.start_y <= sy;
    items_bus.end_x   <= ex;
    items_bus.end_y   <= ey;
    do @(posedge clk); while (!items_bus.ready);
    if (board.note_item(cmd, sx, sy, ex, ey)) sent++;
  endtask

  task automatic load_line(logic [FIELD_BITS-1:0] sx, logic [FIELD_BITS-1:0] sy,
                           logic [FIELD_BITS-1:0] ex, logic [FIELD_BITS-1:0] ey);
    send(CMD_LOAD, sx, sy, ex, ey);
  endtask

  // step items carry junk in the endpoint fields, the block must ignore it
  task automatic step_line(int n);
    for (int k = 0; k < n; k++)
      send(CMD_STEP, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
           FIELD_BITS'($urandom), FIELD_BITS'($urandom));
  endtask

  // stop sending and wait for every traced point, plus the output pipe depth
  task automatic settle();
    items_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_color(logic [FIELD_BITS-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_color(v);
    cfg_we <= 1'b0;
    color_writes++;
  endtask

  // endpoint within d of s, turned around instead of wrapping past 0 or 65535
  function automatic logic [FIELD_BITS-1:0] end_near(logic [FIELD_BITS-1:0] s, int d);
    int e;
    if ($urandom_range(0, 1)) begin
      e = int'(s) + d;
      if (e > 65535) e = int'(s) - d;
    end else begin
      e = int'(s) - d;
      if (e < 0) e = int'(s) + d;
    end
    return e[FIELD_BITS-1:0];
  endfunction

  initial begin
    int                    n;
    int                    r;
    logic [FIELD_BITS-1:0] sx, sy;

    board        = new();
    calm         = 0;
    color_writes = 0;
    sent         = 0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    items_bus.valid   <= 1'b0;
    items_bus.command <= CMD_LOAD;
    items_bus.start_x <= '0;
    items_bus.start_y <= '0;
    items_bus.end_x   <= '0;
    items_bus.end_y   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: step while idle, zero length line at reset color
    step_line(1);
    load_line(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    step_line(3);                       // two points, then ignored
    // all-ones color, line running down in x and up in y across the top edge
    write_color(16'hFFFF);
    load_line(16'hFFFF, 16'h0000, 16'hFFFC, 16'h0002);
    step_line(5);
    // widest diagonal, dropped after three points by a new steep line
    write_color(16'h0000);
    load_line(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    step_line(3);
    load_line(16'd40, 16'd50, 16'd41, 16'd54);
    step_line(6);

    // random: mostly complete short lines, some cut short, some noise
    sent = 0;
    while (sent < 1500) begin
      calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 4) write_color(FIELD_BITS'($urandom));
      r = $urandom_range(0, 99);
      if (r < 75) begin
        sx = FIELD_BITS'($urandom);
        sy = FIELD_BITS'($urandom);
        n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
        load_line(sx, sy, end_near(sx, n),
                  end_near(sy, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                          : $urandom_range(0, 12)));
        if ($urandom_range(0, 99) < 80)
          step_line(int'(board.major) + 2 + $urandom_range(0, 2));
        else
          step_line($urandom_range(0, int'(board.major) + 1));
      end else if (r < 88) begin
        step_line($urandom_range(1, 4));
      end else begin
        // full range endpoints, abandoned after a few points
        load_line(FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                  FIELD_BITS'($urandom), FIELD_BITS'($urandom));
        step_line($urandom_range(0, 3));
      end
    end
    calm = 0;

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d lines and %0d checked points",
             board.lines, board.checked);
    $display("with %0d pen color writes, idle steps and lines cut by reloads",
             color_writes);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
